// ===== hw/rtl/ernn_pkg.sv =====
// Shared types, codes and table-building functions for the Elman network step.
package ernn_pkg;

    localparam int ACC_W = 48;

    typedef enum logic [0:0] {
        KIND_LOAD = 1'b0,
        KIND_ELEM = 1'b1
    } kind_t;

    localparam logic [2:0] MAT_IH   = 3'd0;
    localparam logic [2:0] MAT_HB   = 3'd1;
    localparam logic [2:0] MAT_CTX  = 3'd2;
    localparam logic [2:0] MAT_HO   = 3'd3;
    localparam logic [2:0] MAT_OB   = 3'd4;

    localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
    localparam logic [1:0] REG_HIDDEN_COUNT = 2'd1;
    localparam logic [1:0] REG_OUTPUT_COUNT = 2'd2;
    localparam logic [1:0] REG_RECURRENT    = 2'd3;

    typedef struct packed {
        logic acc_load;
        logic mul_start;
    } mac_ctrl_t;

    // Restoring division, used only while the sigmoid table is built
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_neg_q30(input logic [31:0] t);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] prod;
        logic [63:0] e;
        y    = {32'd0, t} << 14;
        term = 64'd1 << 30;
        pos  = 64'd1 << 30;
        neg  = '0;
        for (int k = 1; k <= 6; k++)
        begin
            prod = term * y;
            term = udiv64(prod >> 30, 64'(k));
            if ((k % 2) == 1)
            begin
                neg = neg + term;
            end
            else
            begin
                pos = pos + term;
            end
        end
        e = pos - neg;
        for (int k = 0; k < 4; k++)
        begin
            prod = e * e;
            e = prod >> 30;
        end
        return e;
    endfunction

    function automatic logic [31:0] sigmoid_exact(input int x);
        logic [31:0] t;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] quo;
        logic [31:0] s;
        t   = (x < 0) ? 32'(-x) : 32'(x);
        e   = exp_neg_q30(t);
        den = (64'd1 << 30) + e;
        quo = udiv64((64'd4096 << 30) + (den >> 1), den);
        s   = quo[31:0];
        return (x < 0) ? (32'd4096 - s) : s;
    endfunction

    function automatic logic [12:0] sig_entry(input int j, input int depth);
        logic [63:0] off;
        logic [31:0] s;
        int          c;
        off = udiv64(64'(j) * 64'd65536 + 64'd32768, 64'(depth));
        c   = -32768 + int'(off[31:0]);
        s   = sigmoid_exact(c);
        return s[12:0];
    endfunction

endpackage

// ===== hw/rtl/ernn_mac.sv =====
// Bit-serial multiply-accumulate: one weight bit per cycle into a wide accumulator.
module ernn_mac
    import ernn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_ctrl_t               ctrl,
    input  logic signed [15:0]      bias,
    input  logic signed [15:0]      a,
    input  logic signed [15:0]      w,
    output logic signed [ACC_W-1:0] acc,
    output logic                    done
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] mcand_reg;
    logic        [15:0]      mplier_reg;
    logic        [3:0]       cnt_reg;
    logic                    busy_reg;
    logic signed [ACC_W-1:0] addend;

    always_comb
    begin
        if (!mplier_reg[0])
        begin
            addend = '0;
        end
        else if (cnt_reg == 4'd15)
        begin
            // sign bit of the weight carries negative weight
            addend = -mcand_reg;
        end
        else
        begin
            addend = mcand_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.mul_start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_load)
        begin
            acc_reg <= ACC_W'(bias) <<< 12;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + addend;
        end
        if (ctrl.mul_start)
        begin
            mcand_reg  <= ACC_W'(a);
            mplier_reg <= w;
        end
        else if (busy_reg)
        begin
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign acc  = acc_reg;
    assign done = busy_reg && (cnt_reg == 4'd15);

endmodule

// ===== hw/rtl/ernn_sig.sv =====
// Sigmoid lookup: constant table over the Q4.12 range, registered read.
module ernn_sig
    import ernn_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic               clk,
    input  logic signed [15:0] x,
    output logic        [12:0] y
);

    localparam int TW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [12:0] rom [DEPTH];
    logic [31:0] prod;
    logic [TW-1:0] idx;
    logic [12:0] y_reg;

    for (genvar j = 0; j < DEPTH; j++)
    begin : g_rom
        localparam logic [12:0] ENTRY = sig_entry(j, DEPTH);
        assign rom[j] = ENTRY;
    end

    // bias the input to unsigned, then scale to the table depth
    assign prod = {16'd0, ~x[15], x[14:0]} * 32'(DEPTH);
    assign idx  = TW'(prod >> 16);

    always_ff @(posedge clk)
    begin
        y_reg <= rom[idx];
    end

    assign y = y_reg;

endmodule

// ===== hw/rtl/elman_rnn_forward_step_top.sv =====
// Elman network forward step: weight stores, sequencer and result register.
//
// Input channel (in_valid / in_stall): each beat either loads one weight or
// bias (kind = 0) or writes one input element (kind = 1). An element with
// last_element set starts a forward pass, and in_stall stays high until the
// pass is over. Each hidden unit loads its bias into the single bit-serial
// multiply-accumulate, then for each context unit (if recurrent) and each
// input element fetches the operands, loads them and runs the 16 weight
// bits through; the sum is rounded, passed through the sigmoid and stored.
// Each output unit does the same over the hidden layer.
// Output channel (out_valid / out_stall): one beat per output unit, in unit
// order, last set on the final one. A stalled beat holds; the sequencer waits
// for the result register before it emits the next unit.
// After the outputs, the hidden layer is copied into the context, and
// start_sequence on an element clears the context at once. Reset clears the
// context and the counts go to their full sizes; weight stores and the input
// vector hold nothing defined until written. The block leaves it to the user
// to write configuration (cfg_we, cfg_index, cfg_data) only while idle.
module elman_rnn_forward_step_top
    import ernn_pkg::*;
#(
    parameter int MAX_INPUTS          = 256,
    parameter int MAX_HIDDEN          = 128,
    parameter int MAX_OUTPUTS         = 64,
    parameter int SIGMOID_TABLE_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [2:0]  weight_matrix,
    input  logic [7:0]  row_index,
    input  logic [6:0]  col_index,
    input  logic signed [15:0] value,
    input  logic        start_sequence,
    input  logic        last_element,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  out_index,
    output logic [12:0] out_value,
    output logic        last
);

    localparam int IA_W  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int HA_W  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
    localparam int OA_W  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int IHA_W = (MAX_INPUTS * MAX_HIDDEN > 1) ? $clog2(MAX_INPUTS * MAX_HIDDEN) : 1;
    localparam int CWA_W = (MAX_HIDDEN * MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN * MAX_HIDDEN) : 1;
    localparam int HOA_W = (MAX_HIDDEN * MAX_OUTPUTS > 1) ? $clog2(MAX_HIDDEN * MAX_OUTPUTS) : 1;
    localparam int SW    = (IA_W > HA_W) ? IA_W : HA_W;
    localparam int UW    = (HA_W > OA_W) ? HA_W : OA_W;
    localparam int NI_W  = $clog2(MAX_INPUTS + 1);
    localparam int NH_W  = $clog2(MAX_HIDDEN + 1);
    localparam int NO_W  = $clog2(MAX_OUTPUTS + 1);

    typedef enum logic [15:0] {
        S_IDLE   = 16'b0000_0000_0000_0001,
        S_HB_RD  = 16'b0000_0000_0000_0010,
        S_HB_ADD = 16'b0000_0000_0000_0100,
        S_MAC_RD = 16'b0000_0000_0000_1000,
        S_MAC_LD = 16'b0000_0000_0001_0000,
        S_MAC    = 16'b0000_0000_0010_0000,
        S_HQ     = 16'b0000_0000_0100_0000,
        S_HSIG   = 16'b0000_0000_1000_0000,
        S_HWR    = 16'b0000_0001_0000_0000,
        S_OB_RD  = 16'b0000_0010_0000_0000,
        S_OB_ADD = 16'b0000_0100_0000_0000,
        S_OQ     = 16'b0000_1000_0000_0000,
        S_OSIG   = 16'b0001_0000_0000_0000,
        S_OEMIT  = 16'b0010_0000_0000_0000,
        S_CPY_RD = 16'b0100_0000_0000_0000,
        S_CPY_WR = 16'b1000_0000_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        P_CTX = 2'd0,
        P_IN  = 2'd1,
        P_OUT = 2'd2
    } phase_t;

    // configuration
    logic [8:0] input_count_reg;
    logic [7:0] hidden_count_reg;
    logic [6:0] output_count_reg;
    logic       recurrent_reg;

    // stores
    logic signed [15:0] iv_mem  [MAX_INPUTS];
    logic signed [15:0] ih_mem  [MAX_INPUTS * MAX_HIDDEN];
    logic signed [15:0] cw_mem  [MAX_HIDDEN * MAX_HIDDEN];
    logic signed [15:0] ho_mem  [MAX_HIDDEN * MAX_OUTPUTS];
    logic signed [15:0] hb_mem  [MAX_HIDDEN];
    logic signed [15:0] ob_mem  [MAX_OUTPUTS];
    logic        [12:0] hid_mem [MAX_HIDDEN];
    logic        [12:0] ctx_mem [MAX_HIDDEN];
    logic               ctx_valid_reg [MAX_HIDDEN];

    logic signed [15:0] iv_rdata, ih_rdata, cw_rdata, ho_rdata, hb_rdata, ob_rdata;
    logic        [12:0] hid_rdata, ctx_rdata;
    logic               ctx_vld_rdata;

    // sequencer
    state_t          state_reg, state_next;
    phase_t          phase_reg, phase_next;
    logic [UW-1:0]   u_reg, u_next;
    logic [SW-1:0]   i_reg, i_next;
    logic [NI_W-1:0] ni_reg, ni_next;
    logic [NH_W-1:0] nh_reg, nh_next;
    logic [NO_W-1:0] no_reg, no_next;
    logic signed [15:0] q_reg, q_next;

    logic        out_valid_reg, out_valid_next;
    logic [5:0]  out_index_reg;
    logic [12:0] out_value_reg;
    logic        last_reg;
    logic        emit;

    logic in_acc;
    logic out_acc;
    int   lim;
    logic i_last;
    logic hu_last;
    logic ou_last;

    mac_ctrl_t          mac_ctrl;
    logic signed [15:0] mac_bias;
    logic signed [15:0] mac_a;
    logic signed [15:0] mac_w;
    logic signed [ACC_W-1:0] acc;
    logic               mac_done;
    logic [12:0]        sig_y;

    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] qf;

    logic [IHA_W-1:0] ih_waddr, ih_raddr;
    logic [CWA_W-1:0] cw_waddr, cw_raddr;
    logic [HOA_W-1:0] ho_waddr, ho_raddr;
    logic [HA_W-1:0]  hid_raddr;

    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_count_reg  <= 9'd256;
            hidden_count_reg <= 8'd128;
            output_count_reg <= 7'd64;
            recurrent_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INPUT_COUNT:  input_count_reg  <= cfg_data;
                REG_HIDDEN_COUNT: hidden_count_reg <= cfg_data[7:0];
                REG_OUTPUT_COUNT: output_count_reg <= cfg_data[6:0];
                REG_RECURRENT:    recurrent_reg    <= cfg_data[0];
                default:          recurrent_reg    <= recurrent_reg;
            endcase
        end
    end

    // store writes from load beats and input element beats
    assign ih_waddr = IHA_W'(int'(row_index) * MAX_HIDDEN + int'(col_index));
    assign cw_waddr = CWA_W'(int'(row_index) * MAX_HIDDEN + int'(col_index));
    assign ho_waddr = HOA_W'(int'(row_index) * MAX_OUTPUTS + int'(col_index));

    always_ff @(posedge clk)
    begin
        if (in_acc && kind == KIND_LOAD)
        begin
            case (weight_matrix)
                MAT_IH:
                begin
                    if (int'(row_index) < MAX_INPUTS && int'(col_index) < MAX_HIDDEN)
                    begin
                        ih_mem[ih_waddr] <= value;
                    end
                end
                MAT_HB:
                begin
                    if (int'(col_index) < MAX_HIDDEN)
                    begin
                        hb_mem[HA_W'(int'(col_index))] <= value;
                    end
                end
                MAT_CTX:
                begin
                    if (int'(row_index) < MAX_HIDDEN && int'(col_index) < MAX_HIDDEN)
                    begin
                        cw_mem[cw_waddr] <= value;
                    end
                end
                MAT_HO:
                begin
                    if (int'(row_index) < MAX_HIDDEN && int'(col_index) < MAX_OUTPUTS)
                    begin
                        ho_mem[ho_waddr] <= value;
                    end
                end
                MAT_OB:
                begin
                    if (int'(col_index) < MAX_OUTPUTS)
                    begin
                        ob_mem[OA_W'(int'(col_index))] <= value;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (in_acc && kind == KIND_ELEM && int'(row_index) < MAX_INPUTS)
        begin
            iv_mem[IA_W'(int'(row_index))] <= value;
        end
    end

    // store reads, every cycle at the sequencer's indices
    assign ih_raddr  = IHA_W'(int'(i_reg[IA_W-1:0]) * MAX_HIDDEN + int'(u_reg[HA_W-1:0]));
    assign cw_raddr  = CWA_W'(int'(i_reg[HA_W-1:0]) * MAX_HIDDEN + int'(u_reg[HA_W-1:0]));
    assign ho_raddr  = HOA_W'(int'(i_reg[HA_W-1:0]) * MAX_OUTPUTS + int'(u_reg[OA_W-1:0]));
    assign hid_raddr = i_reg[HA_W-1:0];

    always_ff @(posedge clk)
    begin
        iv_rdata      <= iv_mem[i_reg[IA_W-1:0]];
        ih_rdata      <= ih_mem[ih_raddr];
        cw_rdata      <= cw_mem[cw_raddr];
        ho_rdata      <= ho_mem[ho_raddr];
        hb_rdata      <= hb_mem[u_reg[HA_W-1:0]];
        ob_rdata      <= ob_mem[u_reg[OA_W-1:0]];
        hid_rdata     <= hid_mem[hid_raddr];
        ctx_rdata     <= ctx_mem[i_reg[HA_W-1:0]];
        ctx_vld_rdata <= ctx_valid_reg[i_reg[HA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_HWR)
        begin
            hid_mem[u_reg[HA_W-1:0]] <= sig_y;
        end
        if (state_reg == S_CPY_WR)
        begin
            ctx_mem[i_reg[HA_W-1:0]] <= hid_rdata;
        end
    end

    // context entries read as zero until the first copy after reset or start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_HIDDEN; k++)
            begin
                ctx_valid_reg[k] <= 1'b0;
            end
        end
        else if (in_acc && kind == KIND_ELEM && start_sequence)
        begin
            for (int k = 0; k < MAX_HIDDEN; k++)
            begin
                ctx_valid_reg[k] <= 1'b0;
            end
        end
        else if (state_reg == S_CPY_WR)
        begin
            ctx_valid_reg[i_reg[HA_W-1:0]] <= 1'b1;
        end
    end

    // round half up, then saturate to Q4.12
    assign rnd = acc + ACC_W'(2048);
    assign qf  = rnd >>> 12;

    always_comb
    begin
        case (phase_reg)
            P_IN:    lim = int'(ni_reg);
            default: lim = int'(nh_reg);
        endcase
    end

    assign i_last  = (int'(i_reg) + 1 == lim);
    assign hu_last = (int'(u_reg) + 1 == int'(nh_reg));
    assign ou_last = (int'(u_reg) + 1 == int'(no_reg));
    assign emit    = (state_reg == S_OEMIT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        case (phase_reg)
            P_CTX:
            begin
                mac_a = ctx_vld_rdata ? $signed({3'b000, ctx_rdata}) : '0;
                mac_w = cw_rdata;
            end
            P_IN:
            begin
                mac_a = iv_rdata;
                mac_w = ih_rdata;
            end
            default:
            begin
                mac_a = $signed({3'b000, hid_rdata});
                mac_w = ho_rdata;
            end
        endcase
        mac_bias = (state_reg == S_OB_ADD) ? ob_rdata : hb_rdata;
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        u_next     = u_reg;
        i_next     = i_reg;
        ni_next    = ni_reg;
        nh_next    = nh_reg;
        no_next    = no_reg;
        q_next     = q_reg;
        mac_ctrl   = '0;

        if (qf > $signed(ACC_W'(32767)))
        begin
            q_next = 16'sh7fff;
        end
        else if (qf < -$signed(ACC_W'(32768)))
        begin
            q_next = -16'sh8000;
        end
        else
        begin
            q_next = qf[15:0];
        end
        if (state_reg != S_HQ && state_reg != S_OQ)
        begin
            q_next = q_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && kind == KIND_ELEM && last_element)
                begin
                    // clamp the counts into their usable ranges
                    if (input_count_reg == '0)
                    begin
                        ni_next = NI_W'(1);
                    end
                    else if (int'(input_count_reg) > MAX_INPUTS)
                    begin
                        ni_next = NI_W'(MAX_INPUTS);
                    end
                    else
                    begin
                        ni_next = NI_W'(int'(input_count_reg));
                    end
                    if (hidden_count_reg == '0)
                    begin
                        nh_next = NH_W'(1);
                    end
                    else if (int'(hidden_count_reg) > MAX_HIDDEN)
                    begin
                        nh_next = NH_W'(MAX_HIDDEN);
                    end
                    else
                    begin
                        nh_next = NH_W'(int'(hidden_count_reg));
                    end
                    if (output_count_reg == '0)
                    begin
                        no_next = NO_W'(1);
                    end
                    else if (int'(output_count_reg) > MAX_OUTPUTS)
                    begin
                        no_next = NO_W'(MAX_OUTPUTS);
                    end
                    else
                    begin
                        no_next = NO_W'(int'(output_count_reg));
                    end
                    u_next     = '0;
                    state_next = S_HB_RD;
                end
            end
            S_HB_RD:
            begin
                state_next = S_HB_ADD;
            end
            S_HB_ADD:
            begin
                mac_ctrl.acc_load = 1'b1;
                phase_next = recurrent_reg ? P_CTX : P_IN;
                i_next     = '0;
                state_next = S_MAC_RD;
            end
            S_MAC_RD:
            begin
                state_next = S_MAC_LD;
            end
            S_MAC_LD:
            begin
                mac_ctrl.mul_start = 1'b1;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                if (mac_done)
                begin
                    if (!i_last)
                    begin
                        i_next     = i_reg + SW'(1);
                        state_next = S_MAC_RD;
                    end
                    else if (phase_reg == P_CTX)
                    begin
                        phase_next = P_IN;
                        i_next     = '0;
                        state_next = S_MAC_RD;
                    end
                    else if (phase_reg == P_IN)
                    begin
                        state_next = S_HQ;
                    end
                    else
                    begin
                        state_next = S_OQ;
                    end
                end
            end
            S_HQ:
            begin
                state_next = S_HSIG;
            end
            S_HSIG:
            begin
                state_next = S_HWR;
            end
            S_HWR:
            begin
                if (hu_last)
                begin
                    u_next     = '0;
                    state_next = S_OB_RD;
                end
                else
                begin
                    u_next     = u_reg + UW'(1);
                    state_next = S_HB_RD;
                end
            end
            S_OB_RD:
            begin
                state_next = S_OB_ADD;
            end
            S_OB_ADD:
            begin
                mac_ctrl.acc_load = 1'b1;
                phase_next = P_OUT;
                i_next     = '0;
                state_next = S_MAC_RD;
            end
            S_OQ:
            begin
                state_next = S_OSIG;
            end
            S_OSIG:
            begin
                state_next = S_OEMIT;
            end
            S_OEMIT:
            begin
                if (emit)
                begin
                    if (ou_last)
                    begin
                        i_next     = '0;
                        state_next = S_CPY_RD;
                    end
                    else
                    begin
                        u_next     = u_reg + UW'(1);
                        state_next = S_OB_RD;
                    end
                end
            end
            S_CPY_RD:
            begin
                state_next = S_CPY_WR;
            end
            S_CPY_WR:
            begin
                if (int'(i_reg) + 1 == int'(nh_reg))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + SW'(1);
                    state_next = S_CPY_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_acc)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= P_IN;
            u_reg         <= '0;
            i_reg         <= '0;
            ni_reg        <= '0;
            nh_reg        <= '0;
            no_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            u_reg         <= u_next;
            i_reg         <= i_next;
            ni_reg        <= ni_next;
            nh_reg        <= nh_next;
            no_reg        <= no_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        if (emit)
        begin
            out_index_reg <= 6'(u_reg);
            out_value_reg <= sig_y;
            last_reg      <= ou_last;
        end
    end

    ernn_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .bias  (mac_bias),
        .a     (mac_a),
        .w     (mac_w),
        .acc   (acc),
        .done  (mac_done)
    );

    ernn_sig #(
        .DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_sig (
        .clk (clk),
        .x   (q_reg),
        .y   (sig_y)
    );

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;

endmodule

// ===== test/ernn_output_checker.sv =====
// Checker for the Elman step: predicts output beats from the channels and compares them.
`timescale 1ns / 100ps

module ernn_output_checker
    import ernn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        kind,
    input  logic [2:0]  weight_matrix,
    input  logic [7:0]  row_index,
    input  logic [6:0]  col_index,
    input  logic signed [15:0] value,
    input  logic        start_sequence,
    input  logic        last_element,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [5:0]  out_index,
    input  logic [12:0] out_value,
    input  logic        last,
    output int          pending,
    output int          errors,
    output int          checked,
    output int          passes
);

    localparam int N_IN  = 256;
    localparam int N_HID = 128;
    localparam int N_OUT = 64;
    localparam int LUT_DEPTH = 1024;

    typedef struct packed {
        logic [5:0]  idx;
        logic [12:0] act;
        logic        fin;
    } out_beat_t;

    out_beat_t expected_outputs[$];

    logic signed [15:0] in_vec [N_IN];
    logic signed [15:0] ih_w [N_IN * N_HID];
    logic signed [15:0] ctx_w [N_HID * N_HID];
    logic signed [15:0] ho_w [N_HID * N_OUT];
    logic signed [15:0] hid_bias [N_HID];
    logic signed [15:0] out_bias [N_OUT];
    logic [12:0] hid_act [N_HID];
    logic [12:0] ctx_act [N_HID];
    logic [12:0] sig_lut [LUT_DEPTH];

    int  n_in_raw;
    int  n_hid_raw;
    int  n_out_raw;
    logic rec_en;

    // e^(-t) at 30 fraction bits: Taylor series of e^(-t/16), then square four times
    function automatic longint unsigned exp_minus(int unsigned t);
        longint unsigned y;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned e;
        y    = longint'(t) << 14;
        term = 64'd1 << 30;
        pos  = 64'd1 << 30;
        neg  = 0;
        for (int k = 1; k <= 6; k++)
        begin
            term = ((term * y) >> 30) / 64'(k);
            if (k % 2 == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        e = pos - neg;
        for (int k = 0; k < 4; k++)
            e = (e * e) >> 30;
        return e;
    endfunction

    function automatic int sig_calc(int x);
        int unsigned t;
        longint unsigned den;
        longint unsigned s;
        t   = (x < 0) ? -x : x;
        den = (64'd1 << 30) + exp_minus(t);
        s   = ((64'd4096 << 30) + (den >> 1)) / den;
        return (x < 0) ? 4096 - int'(s) : int'(s);
    endfunction

    initial
    begin
        for (int j = 0; j < LUT_DEPTH; j++)
            sig_lut[j] = 13'(sig_calc(-32768 + (j * 65536 + 32768) / LUT_DEPTH));
    end

    function automatic logic [12:0] sig_of(int x);
        int idx;
        idx = ((x + 32768) * LUT_DEPTH) >> 16;
        if (idx >= LUT_DEPTH)
            idx = LUT_DEPTH - 1;
        return sig_lut[idx];
    endfunction

    // Round a 24-fraction-bit sum to Q4.12, half up, and saturate
    function automatic int round_sat(longint sm);
        longint off;
        longint q;
        off = 64'sd1 <<< 44;
        if (sm > off - 4096)
            sm = off - 4096;
        if (sm < -off)
            sm = -off;
        q = ((sm + off) + 2048) >>> 12;
        q = q - (64'sd1 <<< 32);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return int'(q);
    endfunction

    function automatic int clamp_count(int v, int hi);
        if (v < 1)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    task automatic forward_pass();
        int ni;
        int nh;
        int no;
        longint acc;
        out_beat_t b;
        ni = clamp_count(n_in_raw, N_IN);
        nh = clamp_count(n_hid_raw, N_HID);
        no = clamp_count(n_out_raw, N_OUT);
        for (int k = 0; k < nh; k++)
        begin
            acc = longint'(hid_bias[k]) * 4096;
            if (rec_en)
                for (int i = 0; i < nh; i++)
                    acc += longint'(ctx_act[i]) * longint'(ctx_w[i * N_HID + k]);
            for (int i = 0; i < ni; i++)
                acc += longint'(in_vec[i]) * longint'(ih_w[i * N_HID + k]);
            hid_act[k] = sig_of(round_sat(acc));
        end
        for (int i = 0; i < no; i++)
        begin
            acc = longint'(out_bias[i]) * 4096;
            for (int k = 0; k < nh; k++)
                acc += longint'(hid_act[k]) * longint'(ho_w[k * N_OUT + i]);
            b.idx = 6'(i);
            b.act = sig_of(round_sat(acc));
            b.fin = (i + 1 == no);
            expected_outputs.push_back(b);
        end
        for (int k = 0; k < nh; k++)
            ctx_act[k] = hid_act[k];
        passes++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            errors    = 0;
            checked   = 0;
            passes    = 0;
            n_in_raw  = 256;
            n_hid_raw = 128;
            n_out_raw = 64;
            rec_en    = 1'b1;
            for (int k = 0; k < N_HID; k++)
            begin
                hid_act[k] = '0;
                ctx_act[k] = '0;
            end
            expected_outputs.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                checked++;
                if (expected_outputs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat index %0d value %0d last %0b",
                             $time, out_index, out_value, last);
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    if (out_index !== want.idx)
                    begin
                        errors++;
                        $display("%0t: out_index expected %0d actual %0d",
                                 $time, want.idx, out_index);
                    end
                    if (out_value !== want.act)
                    begin
                        errors++;
                        $display("%0t: out_value (unit %0d) expected %0d actual %0d",
                                 $time, want.idx, want.act, out_value);
                    end
                    if (last !== want.fin)
                    begin
                        errors++;
                        $display("%0t: last (unit %0d) expected %0b actual %0b",
                                 $time, want.idx, want.fin, last);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INPUT_COUNT:  n_in_raw  = cfg_data;
                    REG_HIDDEN_COUNT: n_hid_raw = cfg_data[7:0];
                    REG_OUTPUT_COUNT: n_out_raw = cfg_data[6:0];
                    REG_RECURRENT:    rec_en    = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (kind == KIND_LOAD)
                begin
                    case (weight_matrix)
                        MAT_IH:  ih_w[row_index * N_HID + col_index] = value;
                        MAT_HB:  hid_bias[col_index] = value;
                        MAT_CTX: if (row_index < N_HID)
                                     ctx_w[row_index * N_HID + col_index] = value;
                        MAT_HO:  if (row_index < N_HID && col_index < N_OUT)
                                     ho_w[row_index * N_OUT + col_index] = value;
                        MAT_OB:  if (col_index < N_OUT)
                                     out_bias[col_index] = value;
                        default: ;
                    endcase
                end
                else
                begin
                    in_vec[row_index] = value;
                    if (start_sequence)
                        for (int k = 0; k < N_HID; k++)
                            ctx_act[k] = '0;
                    if (last_element)
                        forward_pass();
                end
            end
        end
        pending = expected_outputs.size();
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for the Elman step: clock, reset, stimulus, stall patterns and verdict.
`timescale 1ns / 100ps

module tb
    import ernn_pkg::*;
();

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE      = 320;
    localparam int ITEM_TARGET = 470;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [8:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = 1'b0;
    logic [2:0]  weight_matrix = '0;
    logic [7:0]  row_index = '0;
    logic [6:0]  col_index = '0;
    logic signed [15:0] value = '0;
    logic        start_sequence = 1'b0;
    logic        last_element = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [5:0]  out_index;
    logic [12:0] out_value;
    logic        last;

    int pending;
    int errors;
    int checked;
    int passes;

    elman_rnn_forward_step_top DUT (.*);

    ernn_output_checker checker_i (.*);

    initial
    begin
        forever
            #10 clk = ~clk;
    end

    int cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("elman_rnn_forward_step_top test failed");
            $finish;
        end
    end

    // Receiver stall: the pattern is re-chosen at random among free, sparse, dense and held bursts
    int stall_mode = 0;
    int stall_hold = 0;
    always @(posedge clk)
    begin
        if (cycles % 300 == 0)
            stall_mode <= $urandom_range(0, 3);
        if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
            out_stall  <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    out_stall <= 1'b0;
                    if ($urandom_range(0, 15) == 0)
                        stall_hold <= $urandom_range(1, 20);
                end
            endcase
        end
    end

    // Which store entries hold a defined value
    bit ih_ok [256 * 128];
    bit hb_ok [128];
    bit ctx_ok [128 * 128];
    bit ho_ok [128 * 64];
    bit ob_ok [64];
    bit vec_ok [256];

    int ni = 256;
    int nh = 128;
    int no = 64;
    bit rec = 1'b1;
    int items_sent = 0;
    int burst_left = 1;

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3: return 16'($urandom);
            default: return 16'($urandom_range(0, 8191) - 4096);
        endcase
    endfunction

    function automatic int clamp_count(int v, int hi);
        if (v < 1)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    task automatic send_beat(logic k, logic [2:0] m, logic [7:0] r, logic [6:0] c,
                             logic [15:0] v, logic s, logic l);
        int gap;
        in_valid       <= 1'b1;
        kind           <= k;
        weight_matrix  <= m;
        row_index      <= r;
        col_index      <= c;
        value          <= v;
        start_sequence <= s;
        last_element   <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (k == KIND_LOAD)
        begin
            case (m)
                MAT_IH:  ih_ok[r * 128 + c] = 1'b1;
                MAT_HB:  hb_ok[c] = 1'b1;
                MAT_CTX: if (r < 128) ctx_ok[r * 128 + c] = 1'b1;
                MAT_HO:  if (r < 128 && c < 64) ho_ok[r * 64 + c] = 1'b1;
                MAT_OB:  if (c < 64) ob_ok[c] = 1'b1;
                default: ;
            endcase
        end
        else
            vec_ok[r] = 1'b1;
        burst_left--;
        if (burst_left <= 0)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                burst_left = $urandom_range(40, 80);
                gap = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 16);
                gap = $urandom_range(0, 6);
            end
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Load every entry the current sizes will read that has not been written yet
    task automatic fill_missing();
        for (int k = 0; k < nh; k++)
        begin
            if (!hb_ok[k])
                send_beat(KIND_LOAD, MAT_HB, 8'($urandom), 7'(k), pick_value(),
                          1'($urandom), 1'($urandom));
            for (int i = 0; i < ni; i++)
                if (!ih_ok[i * 128 + k])
                    send_beat(KIND_LOAD, MAT_IH, 8'(i), 7'(k), pick_value(), 1'b0, 1'b0);
            if (rec)
                for (int i = 0; i < nh; i++)
                    if (!ctx_ok[i * 128 + k])
                        send_beat(KIND_LOAD, MAT_CTX, 8'(i), 7'(k), pick_value(), 1'b0, 1'b0);
            for (int i = 0; i < no; i++)
                if (!ho_ok[k * 64 + i])
                    send_beat(KIND_LOAD, MAT_HO, 8'(k), 7'(i), pick_value(), 1'b0, 1'b0);
        end
        for (int i = 0; i < no; i++)
            if (!ob_ok[i])
                send_beat(KIND_LOAD, MAT_OB, 8'($urandom), 7'(i), pick_value(), 1'b0, 1'b0);
        for (int i = 0; i < ni; i++)
            if (!vec_ok[i])
                send_beat(KIND_ELEM, 3'($urandom), 8'(i), 7'($urandom), pick_value(), 1'b0, 1'b0);
    endtask

    // One well-formed vector: elements in order, last on the final one
    task automatic run_vector(bit st, int mode);
        logic [15:0] v;
        fill_missing();
        for (int i = 0; i < ni; i++)
        begin
            v = (mode == 1) ? 16'h7FFF : (mode == 2) ? 16'h8000 : pick_value();
            send_beat(KIND_ELEM, 3'($urandom), 8'(i), 7'($urandom), v,
                      st && (i == 0), i == ni - 1);
        end
    endtask

    // Write all registers once the block has drained
    task automatic set_counts(int a, int b, int c, bit r);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_INPUT_COUNT;
        cfg_data <= 9'(a);
        @(posedge clk);
        cfg_index <= REG_HIDDEN_COUNT;
        cfg_data <= 9'(b);
        @(posedge clk);
        cfg_index <= REG_OUTPUT_COUNT;
        cfg_data <= 9'(c);
        @(posedge clk);
        cfg_index <= REG_RECURRENT;
        cfg_data <= 9'(r);
        @(posedge clk);
        cfg_we <= 1'b0;
        ni  = clamp_count(a, 256);
        nh  = clamp_count(b, 128);
        no  = clamp_count(c, 64);
        rec = r;
    endtask

    initial
    begin
        int phase_left;
        int sel;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_counts(4, 3, 2, 1'b1);
        fill_missing();
        // Ignored loads (bad matrix codes, addresses beyond their stores), then in-range loads
        send_beat(KIND_LOAD, 3'd5, 8'hFF, 7'h7F, 16'h7FFF, 1'b1, 1'b1);
        send_beat(KIND_LOAD, 3'd6, 8'h00, 7'h00, 16'h8000, 1'b0, 1'b1);
        send_beat(KIND_LOAD, 3'd7, 8'hAA, 7'h55, 16'h5555, 1'b1, 1'b0);
        send_beat(KIND_LOAD, MAT_CTX, 8'd200, 7'd1, 16'h1234, 1'b0, 1'b0);
        send_beat(KIND_LOAD, MAT_HO, 8'd2, 7'd100, 16'h4321, 1'b0, 1'b0);
        send_beat(KIND_LOAD, MAT_HO, 8'd255, 7'd0, 16'h4321, 1'b0, 1'b0);
        send_beat(KIND_LOAD, MAT_OB, 8'd0, 7'd64, 16'h7FFF, 1'b0, 1'b0);
        send_beat(KIND_LOAD, MAT_IH, 8'd0, 7'd0, 16'h7FFF, 1'b1, 1'b1);
        send_beat(KIND_LOAD, MAT_HB, 8'd0, 7'd1, 16'h8000, 1'b0, 1'b0);
        send_beat(KIND_LOAD, MAT_HO, 8'd0, 7'd0, 16'h7FFF, 1'b0, 1'b0);
        // Element at the top position, start without last
        send_beat(KIND_ELEM, 3'd7, 8'd255, 7'h7F, 16'h8000, 1'b1, 1'b0);
        run_vector(1'b1, 1);
        run_vector(1'b0, 2);
        run_vector(1'b0, 0);
        run_vector(1'b1, 0);

        // Extreme settings: zero counts act as one, an oversize count as the maximum
        set_counts(0, 0, 0, 1'b0);
        run_vector(1'b0, 0);
        run_vector(1'b1, 0);
        set_counts(1, 1, 127, 1'b1);
        run_vector(1'b0, 1);

        phase_left = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase_left <= 0)
            begin
                set_counts($urandom_range(1, 8), $urandom_range(1, 8),
                           $urandom_range(1, 8), 1'($urandom));
                phase_left = $urandom_range(30, 60);
            end
            sel = $urandom_range(0, 9);
            if (sel < 3)
                send_beat(KIND_LOAD, 3'($urandom_range(0, 4)), 8'($urandom_range(0, 7)),
                          7'($urandom_range(0, 7)), pick_value(), 1'($urandom), 1'($urandom));
            else if (sel == 3)
                send_beat(KIND_LOAD, 3'($urandom), 8'($urandom), 7'($urandom),
                          16'($urandom), 1'($urandom), 1'($urandom));
            else if (sel < 8)
                run_vector($urandom_range(0, 4) == 0, 0);
            else if ($urandom_range(0, 3) == 0)
            begin
                // Noise element that fires a pass on whatever the vector holds
                fill_missing();
                send_beat(KIND_ELEM, 3'($urandom), 8'($urandom), 7'($urandom),
                          16'($urandom), 1'($urandom), 1'b1);
            end
            else
                send_beat(KIND_ELEM, 3'($urandom), 8'($urandom), 7'($urandom),
                          16'($urandom), 1'($urandom), 1'b0);
            phase_left--;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d input beats; %0d forward passes, %0d output beats checked.",
                 items_sent, passes, checked);
        $display("Settings ranged from zero counts to an oversize output count, recurrence on and off.");
        if (errors == 0 && pending == 0)
            $display("elman_rnn_forward_step_top test passed");
        else
            $display("elman_rnn_forward_step_top test failed");
        $finish;
    end

endmodule
